### sv/avfv_pkg.sv
`default_nettype none

package avfv_pkg;

    // longest packet accepted before it is flagged as a protocol error
    localparam int MAX_PACKET_BYTES = 1024;

    // byte counter saturates at one past the maximum
    localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 2);
    // width for length compares: counter or 16-bit length plus offset
    localparam int CMP_W = ((CNT_W > 17) ? CNT_W : 17) + 1;

    // stream widths
    localparam int OUT_FIELD_W = 53;
    localparam int OUT_TDATA_W = 56;

    // config port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_PROFILE_ID  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMPANY_ID  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VENDOR_OP   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PASS_OP     = 2'd3;

    localparam logic [15:0] PROFILE_ID_RST = 16'h110E;
    localparam logic [23:0] COMPANY_ID_RST = 24'h001958;
    localparam logic [7:0]  VENDOR_OP_RST  = 8'h00;
    localparam logic [7:0]  PASS_OP_RST    = 8'h7C;

    // check modes
    localparam logic [1:0] MODE_FRAME  = 2'd0;
    localparam logic [1:0] MODE_VENDOR = 2'd1;
    localparam logic [1:0] MODE_PASS   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_TRUNC = 2'd1;
    localparam logic [1:0] ST_FRAG  = 2'd2;
    localparam logic [1:0] ST_PROTO = 2'd3;

    // byte positions within a packet
    localparam int POS_FIRST      = 0;
    localparam int POS_PROFILE_HI = 1;
    localparam int POS_PROFILE_LO = 2;
    localparam int POS_CTYPE      = 3;
    localparam int POS_SUBUNIT    = 4;
    localparam int POS_OPCODE     = 5;
    localparam int POS_COMPANY_HI = 6;
    localparam int POS_COMPANY_MD = 7;
    localparam int POS_COMPANY_LO = 8;
    localparam int POS_PDU        = 9;
    localparam int POS_PDU_TYPE   = 10;
    localparam int POS_PARAM_HI   = 11;
    localparam int POS_PARAM_LO   = 12;

    // header sizes: plain frame, pass-through, vendor-dependent
    localparam int FRAME_HDR_BYTES  = 6;
    localparam int PASS_HDR_BYTES   = 8;
    localparam int VENDOR_HDR_BYTES = 13;

    // panel subunit type with subunit id zero
    localparam logic [7:0] PANEL_SUBUNIT = 8'h48;

    typedef struct packed {
        logic [15:0] profile;
        logic [23:0] company;
        logic [7:0]  vendor_op;
        logic [7:0]  pass_op;
    } cfg_t;

    // header state handed over on the last byte
    typedef struct packed {
        logic [1:0]       mode;
        logic [CNT_W-1:0] size;
        logic [7:0]       first;
        logic [15:0]      profile;
        logic [7:0]       ctype;
        logic [7:0]       subunit;
        logic [7:0]       opcode;
        logic [23:0]      company;
        logic [7:0]       pdu;
        logic [7:0]       pdu_type;
        logic [15:0]      declared_length;
        logic [7:0]       operation;
        logic             trailing_nonzero;
    } snap_t;

    typedef struct packed {
        logic [15:0] payload_length;
        logic        released;
        logic [6:0]  oper_id;
        logic [7:0]  pdu_id;
        logic [7:0]  opcode;
        logic [3:0]  ctype_code;
        logic        resp_flag;
        logic [1:0]  frame_kind;
        logic [3:0]  trans_label;
        logic [1:0]  status;
    } result_t;

endpackage

`default_nettype wire

### sv/avfv_tracker.sv
`default_nettype none

module avfv_tracker (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire  [7:0]                         in_data,
    input  wire                                in_last,
    input  wire  [1:0]                         in_mode,
    output logic                               snap_valid,
    input  wire                                snap_ready,
    output avfv_pkg::snap_t                    snap
);
    import avfv_pkg::*;

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_data_reg;
    logic             in_last_reg;
    logic [1:0]       in_mode_reg;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] cnt_inc;
    logic [1:0]       mode_reg, mode_next;
    logic             trail_reg, trail_next;
    logic [7:0]       first_reg, first_next;
    logic [15:0]      profile_reg, profile_next;
    logic [7:0]       ctype_reg, ctype_next;
    logic [7:0]       subunit_reg, subunit_next;
    logic [7:0]       opcode_reg, opcode_next;
    logic [23:0]      company_reg, company_next;
    logic [7:0]       pdu_reg, pdu_next;
    logic [7:0]       pdu_type_reg, pdu_type_next;
    logic [15:0]      decl_reg, decl_next;
    logic [7:0]       oper_reg, oper_next;

    logic             snap_valid_reg, snap_valid_next;
    snap_t            snap_reg, snap_next;

    logic             consume;
    logic [CMP_W-1:0] idx_ext;
    logic             hit_vendor, hit_pass;

    // a byte leaves the input register unless it closes a packet and the snapshot is full
    assign consume  = in_valid_reg && (!in_last_reg || snap_ready || !snap_valid_reg);
    assign in_ready = !in_valid_reg || consume;

    // input register
    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_ready) begin
            in_valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            in_data_reg <= in_data;
            in_last_reg <= in_last;
            in_mode_reg <= in_mode;
        end
    end

    // header latching and byte counting
    always_comb begin
        mode_next     = mode_reg;
        first_next    = first_reg;
        profile_next  = profile_reg;
        ctype_next    = ctype_reg;
        subunit_next  = subunit_reg;
        opcode_next   = opcode_reg;
        company_next  = company_reg;
        pdu_next      = pdu_reg;
        pdu_type_next = pdu_type_reg;
        decl_next     = decl_reg;
        oper_next     = oper_reg;

        if (cnt_reg == '0) begin
            mode_next = (in_mode_reg == MODE_UNUSED) ? MODE_FRAME : in_mode_reg;
        end

        unique case (cnt_reg)
            CNT_W'(POS_FIRST):      first_next = in_data_reg;
            CNT_W'(POS_PROFILE_HI): profile_next = {in_data_reg, profile_reg[7:0]};
            CNT_W'(POS_PROFILE_LO): profile_next = {profile_reg[15:8], in_data_reg};
            CNT_W'(POS_CTYPE):      ctype_next = in_data_reg;
            CNT_W'(POS_SUBUNIT):    subunit_next = in_data_reg;
            CNT_W'(POS_OPCODE):     opcode_next = in_data_reg;
            CNT_W'(POS_COMPANY_HI): begin
                company_next = {in_data_reg, 16'h0000};
                oper_next    = in_data_reg;
            end
            CNT_W'(POS_COMPANY_MD): begin
                company_next = {company_reg[23:16], in_data_reg, company_reg[7:0]};
                if (mode_reg == MODE_PASS) begin
                    decl_next = {8'h00, in_data_reg};
                end
            end
            CNT_W'(POS_COMPANY_LO): company_next = {company_reg[23:8], in_data_reg};
            CNT_W'(POS_PDU):        pdu_next = in_data_reg;
            CNT_W'(POS_PDU_TYPE):   pdu_type_next = in_data_reg;
            CNT_W'(POS_PARAM_HI): begin
                if (mode_reg == MODE_VENDOR) begin
                    decl_next = {in_data_reg, 8'h00};
                end
            end
            CNT_W'(POS_PARAM_LO): begin
                if (mode_reg == MODE_VENDOR) begin
                    decl_next = {decl_reg[15:8], in_data_reg};
                end
            end
            default: begin
            end
        endcase
    end

    // nonzero bytes past the declared length
    assign idx_ext    = CMP_W'(cnt_reg);
    assign hit_vendor = (mode_reg == MODE_VENDOR) && (cnt_reg >= CNT_W'(VENDOR_HDR_BYTES))
                        && (idx_ext >= CMP_W'(VENDOR_HDR_BYTES) + CMP_W'(decl_next));
    assign hit_pass   = (mode_reg == MODE_PASS) && (cnt_reg >= CNT_W'(PASS_HDR_BYTES))
                        && (idx_ext >= CMP_W'(PASS_HDR_BYTES) + CMP_W'(decl_next));

    always_comb begin
        if (cnt_reg == '0) begin
            trail_next = 1'b0;
        end else begin
            trail_next = trail_reg || ((in_data_reg != 8'h00) && (hit_vendor || hit_pass));
        end
    end

    // saturating count, cleared after the last byte
    assign cnt_inc = (cnt_reg <= CNT_W'(MAX_PACKET_BYTES)) ? cnt_reg + 1'b1 : cnt_reg;
    assign cnt_next = in_last_reg ? '0 : cnt_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            mode_reg  <= MODE_FRAME;
            trail_reg <= 1'b0;
        end else if (consume) begin
            cnt_reg   <= cnt_next;
            mode_reg  <= mode_next;
            trail_reg <= trail_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume) begin
            first_reg    <= first_next;
            profile_reg  <= profile_next;
            ctype_reg    <= ctype_next;
            subunit_reg  <= subunit_next;
            opcode_reg   <= opcode_next;
            company_reg  <= company_next;
            pdu_reg      <= pdu_next;
            pdu_type_reg <= pdu_type_next;
            decl_reg     <= decl_next;
            oper_reg     <= oper_next;
        end
    end

    // snapshot register, loaded on the last byte
    always_comb begin
        snap_next.mode             = mode_next;
        snap_next.size             = cnt_inc;
        snap_next.first            = first_next;
        snap_next.profile          = profile_next;
        snap_next.ctype            = ctype_next;
        snap_next.subunit          = subunit_next;
        snap_next.opcode           = opcode_next;
        snap_next.company          = company_next;
        snap_next.pdu              = pdu_next;
        snap_next.pdu_type         = pdu_type_next;
        snap_next.declared_length  = decl_next;
        snap_next.operation        = oper_next;
        snap_next.trailing_nonzero = trail_next;
    end

    always_comb begin
        snap_valid_next = snap_valid_reg;
        if (snap_ready || !snap_valid_reg) begin
            snap_valid_next = consume && in_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else begin
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && in_last_reg) begin
            snap_reg <= snap_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

`default_nettype wire

### sv/avfv_checker.sv
`default_nettype none

module avfv_checker (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  avfv_pkg::cfg_t      cfg,
    input  wire                 snap_valid,
    output logic                snap_ready,
    input  avfv_pkg::snap_t     snap,
    output logic                res_valid,
    input  wire                 res_ready,
    output avfv_pkg::result_t   res
);
    import avfv_pkg::*;

    logic             res_valid_reg, res_valid_next;
    result_t          res_reg, res_next;
    logic [1:0]       status;
    logic [CMP_W-1:0] size_ext;
    logic [CMP_W-1:0] frame_len;
    logic             long_pkt;

    assign snap_ready = !res_valid_reg || res_ready;

    assign size_ext  = CMP_W'(snap.size);
    assign frame_len = size_ext - CMP_W'(FRAME_HDR_BYTES);
    assign long_pkt  = size_ext > CMP_W'(MAX_PACKET_BYTES);

    // status in check order
    always_comb begin
        status = ST_OK;
        priority if (long_pkt) begin
            status = ST_PROTO;
        end else if (size_ext < CMP_W'(FRAME_HDR_BYTES)) begin
            status = ST_TRUNC;
        end else if (snap.first[3:2] != 2'b00) begin
            status = ST_FRAG;
        end else if (snap.first[0] || (snap.profile != cfg.profile)
                     || (snap.ctype[7:4] != 4'h0)) begin
            status = ST_PROTO;
        end else if (snap.subunit != PANEL_SUBUNIT) begin
            status = ST_PROTO;
        end else if (snap.mode == MODE_VENDOR) begin
            priority if (snap.opcode != cfg.vendor_op) begin
                status = ST_PROTO;
            end else if (size_ext < CMP_W'(VENDOR_HDR_BYTES)) begin
                status = ST_TRUNC;
            end else if ((snap.company != cfg.company) || (snap.pdu_type != 8'h00)) begin
                status = ST_PROTO;
            end else if (CMP_W'(snap.declared_length) + CMP_W'(VENDOR_HDR_BYTES) > size_ext)
            begin
                status = ST_TRUNC;
            end else if (snap.trailing_nonzero) begin
                status = ST_PROTO;
            end else begin
                status = ST_OK;
            end
        end else if (snap.mode == MODE_PASS) begin
            priority if (size_ext < CMP_W'(PASS_HDR_BYTES)) begin
                status = ST_TRUNC;
            end else if (snap.opcode != cfg.pass_op) begin
                status = ST_PROTO;
            end else if (CMP_W'(snap.declared_length) + CMP_W'(PASS_HDR_BYTES) > size_ext)
            begin
                status = ST_TRUNC;
            end else if (snap.trailing_nonzero) begin
                status = ST_PROTO;
            end else begin
                status = ST_OK;
            end
        end else begin
            status = ST_OK;
        end
    end

    // decoded fields, zero unless ok
    always_comb begin
        res_next        = '0;
        res_next.status = status;
        if (status == ST_OK) begin
            res_next.trans_label = snap.first[7:4];
            res_next.frame_kind  = snap.first[3:2];
            res_next.resp_flag   = snap.first[1];
            res_next.ctype_code  = snap.ctype[3:0];
            res_next.opcode      = snap.opcode;
            unique case (snap.mode)
                MODE_VENDOR: begin
                    res_next.pdu_id         = snap.pdu;
                    res_next.payload_length = snap.declared_length;
                end
                MODE_PASS: begin
                    res_next.oper_id        = snap.operation[6:0];
                    res_next.released       = snap.operation[7];
                    res_next.payload_length = snap.declared_length;
                end
                default: begin
                    res_next.payload_length = frame_len[15:0];
                end
            endcase
        end
    end

    // result register
    always_comb begin
        res_valid_next = res_valid_reg;
        if (snap_ready) begin
            res_valid_next = snap_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_ready && snap_valid) begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

### sv/avfv_validator.sv
`default_nettype none

module avfv_validator (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               cfg_wr_en,
    input  wire  [1:0]        cfg_index,
    input  wire  [23:0]       cfg_wdata,
    output avfv_pkg::cfg_t    cfg
);
    import avfv_pkg::*;

    cfg_t cfg_reg, cfg_next;

    // register writes by index
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PROFILE_ID: cfg_next.profile   = cfg_wdata[15:0];
                REG_COMPANY_ID: cfg_next.company   = cfg_wdata[23:0];
                REG_VENDOR_OP:  cfg_next.vendor_op = cfg_wdata[7:0];
                REG_PASS_OP:    cfg_next.pass_op   = cfg_wdata[7:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.profile   <= PROFILE_ID_RST;
            cfg_reg.company   <= COMPANY_ID_RST;
            cfg_reg.vendor_op <= VENDOR_OP_RST;
            cfg_reg.pass_op   <= PASS_OP_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### sv/avctp_avrcp_frame_validator.sv
// Control-channel frame validator.
// Input stream: one packet byte per transaction in s_tdata, s_tlast on the final
// byte, and the check mode in s_tuser, sampled on the first byte of each packet
// (0 plain frame, 1 vendor-dependent, 2 pass-through, 3 handled as plain frame).
// Output stream: one result transaction per packet, issued for the byte that
// carries s_tlast; status plus the decoded header fields, all zero but status
// when the packet fails a check. Packets longer than MAX_PACKET_BYTES fail.
// Config: cfg_wr_en/cfg_index/cfg_wdata write the expected profile id, company
// id and the vendor and pass-through opcodes; write only while no packet is open.
// Throughput: one byte per cycle, except while a last byte waits on a full snapshot
// register. A byte passes an input register, the header tracker into a snapshot
// register, then the check logic into the result register.
// Stall: with m_tready low the result is held; bytes of later packets still
// flow in until a last byte finds the snapshot and result registers full.
// Reset (aresetn low, synchronous): all stages empty, byte count cleared, config
// registers back to their defaults.
`default_nettype none

module avctp_avrcp_frame_validator (
    input  wire         aclk,
    input  wire         aresetn,
    // input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,    // [7:0] data_byte
    input  wire         s_tlast,    // last_byte
    input  wire  [1:0]  s_tuser,    // [1:0] mode
    // result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    // [1:0] status, [5:2] trans_label, [7:6] frame_kind,
    // [8] resp_flag, [12:9] ctype_code, [20:13] opcode,
    // [28:21] pdu_id, [35:29] oper_id, [36] released,
    // [52:37] payload_length, [55:53] zero
    output logic [55:0] m_tdata,
    // config write port
    input  wire         cfg_wr_en,
    input  wire  [1:0]  cfg_index,
    input  wire  [23:0] cfg_wdata
);
    import avfv_pkg::*;

    cfg_t    cfg;
    snap_t   snap;
    logic    snap_valid;
    logic    snap_ready;
    result_t res;

    avfv_validator u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    avfv_tracker u_tracker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata),
        .in_last    (s_tlast),
        .in_mode    (s_tuser),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap)
    );

    avfv_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    // pack result fields, lowest field first
    assign m_tdata = {(OUT_TDATA_W - OUT_FIELD_W)'(0), res};

endmodule

`default_nettype wire
